// ----- rtl/swm_pkg.sv -----
// Shared types and constants for the sliding window maximum filter.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  localparam int unsigned SAMPLE_W       = 32;
  localparam int unsigned CFG_W          = 7;
  localparam int unsigned AGE_W          = 7;
  localparam int unsigned WINDOW_MAX_DEF = 64;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd3;

  // One entry of the candidate queue.
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] value;
    logic [AGE_W-1:0]           age;
  } cand_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                       step;   // a sample word is taken in this cycle
    logic                       clear;  // sample starts a new sequence
    logic                       shift;  // head expires: move the queue down one place
    logic signed [SAMPLE_W-1:0] sample;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/swm_cell.sv -----
// One place of the candidate queue: holds a value and its age.
`timescale 1ns / 1ps
`default_nettype none

module swm_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  swm_pkg::cell_ctrl_t ctrl_i,
  input  swm_pkg::cand_t      right_i,       // neighbor toward the tail
  input  wire                 right_keep_i,
  input  wire                 prev_keep_i,   // place ahead survives (head: always)
  output logic                keep_o,
  output swm_pkg::cand_t      cand_o,
  output swm_pkg::cand_t      cand_d_o
);

  logic                                valid_q;
  logic signed [swm_pkg::SAMPLE_W-1:0] value_q;
  logic [swm_pkg::AGE_W-1:0]           age_q;
  swm_pkg::cand_t                      own;
  swm_pkg::cand_t                      src;
  logic                                src_keep;
  swm_pkg::cand_t                      cand_d;

  assign own.valid = valid_q;
  assign own.value = value_q;
  assign own.age   = age_q;
  assign cand_o    = own;
  assign cand_d_o  = cand_d;

  // Drop entries dominated by the incoming sample, or all on a new sequence.
  assign keep_o = valid_q &&
                  (!ctrl_i.step || (!ctrl_i.clear && (value_q > ctrl_i.sample)));

  always_comb begin
    src      = ctrl_i.shift ? right_i : own;
    src_keep = ctrl_i.shift ? right_keep_i : keep_o;
    cand_d   = src;
    if (src_keep) begin
      cand_d.valid = 1'b1;
      cand_d.age   = src.age + swm_pkg::AGE_W'(ctrl_i.step);
    end else if (ctrl_i.step && prev_keep_i) begin
      // first free place after the survivors takes the new sample
      cand_d.valid = 1'b1;
      cand_d.value = ctrl_i.sample;
      cand_d.age   = '0;
    end else begin
      cand_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cand_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= cand_d.value;
    age_q   <= cand_d.age;
  end

endmodule

`default_nettype wire

// ----- rtl/sliding_window_maximum.sv -----
// Top level of the sliding window maximum filter: queue of cells and sequencing.
//
//   channel   direction  handshake             payload
//   s_axis    in         tvalid/tready         tdata = sample, tuser = start_req
//   m_axis    out        tvalid/tready         tdata = window_max
//   cfg       in         cfg_valid/cfg_ready   cfg_data = window_size
//
// One sample word per cycle unless pruning or a stalled result holds it off:
// the whole queue of candidates steps at once, every cell comparing against
// the new sample in parallel. After a window_size write the queue drops
// expired heads, one per cycle, and takes no sample meanwhile.
// Reset empties the queue and sets window_size to 3; a stalled result holds
// in the output register and blocks new samples until taken.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_maximum #(
  parameter int unsigned WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire  [swm_pkg::SAMPLE_W-1:0]    s_axis_tdata,   // [31:0] sample
  input  wire                             s_axis_tuser,   // [0] start_req
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  output logic [swm_pkg::SAMPLE_W-1:0]    m_axis_tdata,   // [31:0] window_max
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [swm_pkg::CFG_W-1:0]       cfg_data_i
);

  logic [swm_pkg::CFG_W-1:0]    win_q;
  logic [swm_pkg::CFG_W-1:0]    eff_win;
  logic                         prune_q;
  logic [swm_pkg::CFG_W-1:0]    seen_q;
  logic [swm_pkg::CFG_W-1:0]    seen_base;
  logic [swm_pkg::CFG_W-1:0]    seen_clamp;
  logic [swm_pkg::CFG_W-1:0]    seen_d;
  logic                         out_valid_q;
  logic [swm_pkg::SAMPLE_W-1:0] out_data_q;
  logic                         in_fire;
  logic                         head_expired;
  swm_pkg::cell_ctrl_t          ctrl;

  swm_pkg::cand_t cand     [WINDOW_MAX];
  swm_pkg::cand_t cand_d   [WINDOW_MAX];
  swm_pkg::cand_t right    [WINDOW_MAX];
  logic           keep     [WINDOW_MAX];
  logic           rkeep    [WINDOW_MAX];
  logic           pkeep    [WINDOW_MAX];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !prune_q && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Zero acts as one, sizes above the cell count saturate.
  always_comb begin
    eff_win = win_q;
    if (win_q == '0) begin
      eff_win = swm_pkg::CFG_W'(1);
    end else if (32'(win_q) > 32'(WINDOW_MAX)) begin
      eff_win = swm_pkg::CFG_W'(WINDOW_MAX);
    end
  end

  // Head is out of the window once the next step ages it to the window size.
  assign head_expired = cand[0].valid &&
                        (({1'b0, cand[0].age} + 8'd1) >= {1'b0, eff_win});

  assign ctrl.step   = in_fire;
  assign ctrl.clear  = s_axis_tuser;
  assign ctrl.shift  = head_expired && (in_fire || prune_q);
  assign ctrl.sample = s_axis_tdata;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    if (i == WINDOW_MAX - 1) begin : g_tail
      assign right[i] = '0;
      assign rkeep[i] = 1'b0;
    end else begin : g_mid
      assign right[i] = cand[i+1];
      assign rkeep[i] = keep[i+1];
    end
    if (i == 0) begin : g_head
      assign pkeep[i] = 1'b1;
    end else begin : g_body
      assign pkeep[i] = ctrl.shift ? keep[i] : keep[i-1];
    end

    swm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .right_i      (right[i]),
      .right_keep_i (rkeep[i]),
      .prev_keep_i  (pkeep[i]),
      .keep_o       (keep[i]),
      .cand_o       (cand[i]),
      .cand_d_o     (cand_d[i])
    );
  end

  // Count samples of the sequence, clamped to the current window.
  always_comb begin
    seen_base  = s_axis_tuser ? '0 : seen_q;
    seen_clamp = (seen_base > eff_win) ? eff_win : seen_base;
    seen_d     = (seen_clamp < eff_win) ? seen_clamp + swm_pkg::CFG_W'(1) : seen_clamp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= swm_pkg::WINDOW_RESET;
      prune_q     <= 1'b0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        win_q   <= cfg_data_i;
        prune_q <= 1'b1;
      end else if (prune_q && !head_expired) begin
        prune_q <= 1'b0;
      end
      if (in_fire) begin
        seen_q      <= seen_d;
        out_valid_q <= (seen_d == eff_win);
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= cand_d[0].value;
    end
  end

endmodule

`default_nettype wire
